/* hdl/assert_macros.svh */
// Assertion macros used by the RTL of the UUID text parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define UTP_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define UTP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/utp_pkg.sv */
// Types, constants and decode functions of the UUID text parser.
`default_nettype none

package utp_pkg;

  localparam int UUID_LEN   = 36;
  localparam int UUID_BYTES = 16;
  localparam int POS_W      = 6;
  localparam int BYTE_IDX_W = $clog2(UUID_BYTES);

  typedef logic [POS_W-1:0]      utp_pos_t;
  typedef logic [BYTE_IDX_W-1:0] utp_idx_t;

  localparam utp_pos_t POS_LAST    = POS_W'(UUID_LEN - 1);
  localparam utp_pos_t POS_SAT     = POS_W'(UUID_LEN + 1);
  localparam utp_pos_t POS_VERSION = POS_W'(14);
  localparam utp_pos_t POS_VARIANT = POS_W'(21);

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_8    = 8'h38;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UB   = 8'h42;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;

  // One accepted character handed to the accumulator
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] ch;
  } utp_step_t;

  // Result of one text
  typedef struct packed {
    logic        valid_res;
    logic [63:0] guid_high;
    logic [63:0] guid_low;
  } utp_res_t;

  // Role of a text position
  typedef struct packed {
    logic     beyond;
    logic     is_dash;
    logic     is_second;
    utp_idx_t idx;
  } utp_kind_t;

  // Decoded character
  typedef struct packed {
    logic       err;
    logic       wr_byte;
    utp_idx_t   idx;
    logic [7:0] byte_val;
    logic       wr_first;
    logic [3:0] first_val;
  } utp_dec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } utp_hex_t;

  function automatic utp_kind_t mk_kind(logic dash, logic second, int unsigned idx);
    utp_kind_t k;
    k.beyond    = 1'b0;
    k.is_dash   = dash;
    k.is_second = second;
    k.idx       = BYTE_IDX_W'(idx);
    return k;
  endfunction

  // Pair layout: bytes 8 and 9 are swapped in the text
  function automatic utp_kind_t pos_kind(utp_pos_t pos);
    utp_kind_t k;
    unique case (pos)
      6'd0:  k = mk_kind(1'b0, 1'b0, 0);
      6'd1:  k = mk_kind(1'b0, 1'b1, 0);
      6'd2:  k = mk_kind(1'b0, 1'b0, 1);
      6'd3:  k = mk_kind(1'b0, 1'b1, 1);
      6'd4:  k = mk_kind(1'b0, 1'b0, 2);
      6'd5:  k = mk_kind(1'b0, 1'b1, 2);
      6'd6:  k = mk_kind(1'b0, 1'b0, 3);
      6'd7:  k = mk_kind(1'b0, 1'b1, 3);
      6'd8:  k = mk_kind(1'b1, 1'b0, 0);
      6'd9:  k = mk_kind(1'b0, 1'b0, 4);
      6'd10: k = mk_kind(1'b0, 1'b1, 4);
      6'd11: k = mk_kind(1'b0, 1'b0, 5);
      6'd12: k = mk_kind(1'b0, 1'b1, 5);
      6'd13: k = mk_kind(1'b1, 1'b0, 0);
      6'd14: k = mk_kind(1'b0, 1'b0, 6);
      6'd15: k = mk_kind(1'b0, 1'b1, 6);
      6'd16: k = mk_kind(1'b0, 1'b0, 7);
      6'd17: k = mk_kind(1'b0, 1'b1, 7);
      6'd18: k = mk_kind(1'b1, 1'b0, 0);
      6'd19: k = mk_kind(1'b0, 1'b0, 9);
      6'd20: k = mk_kind(1'b0, 1'b1, 9);
      6'd21: k = mk_kind(1'b0, 1'b0, 8);
      6'd22: k = mk_kind(1'b0, 1'b1, 8);
      6'd23: k = mk_kind(1'b1, 1'b0, 0);
      6'd24: k = mk_kind(1'b0, 1'b0, 10);
      6'd25: k = mk_kind(1'b0, 1'b1, 10);
      6'd26: k = mk_kind(1'b0, 1'b0, 11);
      6'd27: k = mk_kind(1'b0, 1'b1, 11);
      6'd28: k = mk_kind(1'b0, 1'b0, 12);
      6'd29: k = mk_kind(1'b0, 1'b1, 12);
      6'd30: k = mk_kind(1'b0, 1'b0, 13);
      6'd31: k = mk_kind(1'b0, 1'b1, 13);
      6'd32: k = mk_kind(1'b0, 1'b0, 14);
      6'd33: k = mk_kind(1'b0, 1'b1, 14);
      6'd34: k = mk_kind(1'b0, 1'b0, 15);
      6'd35: k = mk_kind(1'b0, 1'b1, 15);
      default: begin
        k        = mk_kind(1'b0, 1'b0, 0);
        k.beyond = 1'b1;
      end
    endcase
    return k;
  endfunction

  function automatic utp_hex_t hex_decode(logic [7:0] c);
    utp_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    priority if (c >= CH_0 && c <= CH_9) begin
      h.val = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      h.val = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.val = 4'(c - CH_UA + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* hdl/utp_stream_if.sv */
// Valid/ready channels of the UUID text parser: character in, result out.
`default_nettype none

interface utp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface utp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [63:0] guid_high;
  logic [63:0] guid_low;
  modport source (output valid, output valid_res, output guid_high, output guid_low,
                  input ready);
  modport sink   (input valid, input valid_res, input guid_high, input guid_low,
                  output ready);
endinterface

`default_nettype wire

/* hdl/utp_char_decode.sv */
// Per-character decode: position role, hex digit, format checks.
`default_nettype none

module utp_char_decode (
  input  utp_pkg::utp_pos_t pos,
  input  logic [7:0]        ch,
  input  logic [3:0]        first_digit,
  output utp_pkg::utp_dec_t dec
);
  import utp_pkg::*;

  utp_kind_t kind;
  utp_hex_t  hx;
  logic      bad_version;
  logic      bad_variant;
  logic      is_first;

  always_comb begin
    kind        = pos_kind(pos);
    hx          = hex_decode(ch);
    is_first    = !kind.beyond && !kind.is_dash && !kind.is_second;
    bad_version = (pos == POS_VERSION) && !(ch >= CH_1 && ch <= CH_5);
    bad_variant = (pos == POS_VARIANT) &&
                  (ch != CH_8) && (ch != CH_9) && (ch != CH_UA) && (ch != CH_UB);

    dec.err = kind.beyond
            | (kind.is_dash && ch != CH_DASH)
            | bad_version
            | bad_variant
            | (is_first && !hx.ok);

    dec.wr_byte   = !kind.beyond && kind.is_second;
    dec.idx       = kind.idx;
    // non-hex second digit: the byte is the first digit alone
    dec.byte_val  = hx.ok ? {first_digit, hx.val} : {4'd0, first_digit};
    dec.wr_first  = is_first;
    dec.first_val = hx.ok ? hx.val : 4'd0;
  end

endmodule

`default_nettype wire

/* hdl/utp_accum.sv */
// Text state: position counter, error flag, byte store and result forming.
`default_nettype none

module utp_accum (
  input  logic               clk,
  input  logic               rst,
  input  utp_pkg::utp_step_t step,
  output utp_pkg::utp_res_t  res,
  output utp_pkg::utp_pos_t  pos
);
  import utp_pkg::*;

  logic       err;
  logic [3:0] first_digit;
  logic [7:0] bytes [UUID_BYTES];

  utp_pos_t   pos_next;
  logic       err_next;
  logic [7:0] bytes_next [UUID_BYTES];
  utp_dec_t   dec;
  logic       ok;

  utp_char_decode u_dec (
    .pos         (pos),
    .ch          (step.ch),
    .first_digit (first_digit),
    .dec         (dec)
  );

  always_comb begin
    err_next = err | dec.err;
    pos_next = (pos == POS_SAT) ? pos : pos + 1'b1;
    for (int k = 0; k < UUID_BYTES; k++) begin
      bytes_next[k] = (dec.wr_byte && dec.idx == BYTE_IDX_W'(k)) ? dec.byte_val : bytes[k];
    end
    ok = !err_next && (pos == POS_LAST);
    res.valid_res = ok;
    res.guid_high = '0;
    res.guid_low  = '0;
    if (ok) begin
      for (int k = 0; k < UUID_BYTES / 2; k++) begin
        res.guid_high[63 - 8*k -: 8] = bytes_next[k];
        res.guid_low[63 - 8*k -: 8]  = bytes_next[k + UUID_BYTES / 2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      err <= 1'b0;
    end else if (step.fire) begin
      if (step.last) begin
        pos <= '0;
        err <= 1'b0;
      end else begin
        pos <= pos_next;
        err <= err_next;
      end
    end
  end

  // every byte of a valid text is rewritten before use, so no clearing
  always_ff @(posedge clk) begin
    if (step.fire) begin
      if (dec.wr_first) begin
        first_digit <= dec.first_val;
      end
      for (int k = 0; k < UUID_BYTES; k++) begin
        bytes[k] <= bytes_next[k];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/uuid_text_parser.sv */
// Top level of the UUID text parser: character beats in, one result beat per text.
// The last character of a text passes the input register; its result then goes to the result register.
// Throughput: one character beat per cycle, sustained, with the result side ready.
// Path: input register -> position decode and byte update -> result register.
// Reset (rst, synchronous): clears the valid flags, position counter and error flag;
// the byte store and first-digit register are rewritten by every text before use.
`default_nettype none
`include "assert_macros.svh"

module uuid_text_parser (
  input  logic             clk,
  input  logic             rst,
  utp_in_if.sink           text,
  utp_out_if.source        result
);
  import utp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;

  // result register
  logic        res_valid;
  logic        res_ok;
  logic [63:0] res_high;
  logic [63:0] res_low;

  logic      out_free;
  logic      s1_adv;
  logic      res_zero;
  utp_step_t step;
  utp_res_t  res;
  utp_pos_t  pos;

  // Only a last character needs the result register; others always move on.
  assign out_free   = !res_valid || result.ready;
  assign s1_adv     = s1_valid && (!s1_last || out_free);
  assign text.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_ch   <= text.ch;
      s1_last <= text.last;
    end
  end

  assign step.fire = s1_adv;
  assign step.last = s1_last;
  assign step.ch   = s1_ch;

  utp_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .res  (res),
    .pos  (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      res_ok   <= res.valid_res;
      res_high <= res.guid_high;
      res_low  <= res.guid_low;
    end
  end

  assign result.valid     = res_valid;
  assign result.valid_res = res_ok;
  assign result.guid_high = res_high;
  assign result.guid_low  = res_low;

  assign res_zero = (res_high == '0) && (res_low == '0);

  // checks
  `UTP_CHECK(a_pos_range, pos <= POS_SAT, "position counter past saturation")
  `UTP_CHECK_NEXT(a_pos_restart, s1_adv && s1_last, pos == '0, "position not cleared")
  `UTP_CHECK_NEXT(a_result_loaded, s1_adv && s1_last, res_valid, "no result beat")
  `UTP_CHECK(a_invalid_zero, !res_valid || res_ok || res_zero, "invalid text with bytes")

endmodule

`default_nettype wire

/* dv/uuid_text_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the UUID text parser: directed and random texts with random stalls.

module uuid_text_parser_test;
  import utp_pkg::*;

  // A long run of cycles with no beat on either side means the block has hung.
  // The slowest correct stretch is a sender gap plus a result stall
  // plus the path through the parser, so the limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_TEXT       = 64;
  // A quiet spell after the drain catches any stray result beat.
  localparam int DRAIN_CYCLES   = 8;

  // Ways a well-formed text gets broken
  typedef enum int {
    BREAK_DASH,
    BREAK_VERSION,
    BREAK_VARIANT,
    BREAK_FIRST_DIGIT,
    BREAK_SHORT,
    BREAK_LONG,
    BREAK_COUNT
  } break_kind_e;

  logic clk;
  logic rst;

  utp_in_if  text_if ();
  utp_out_if result_if ();

  uuid_text_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .result (result_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a model of the parser state, stepped once per accepted character
  // ---------------------------------------------------------------------------
  logic [5:0] text_pos;          // characters seen, saturating just past the end
  logic       text_bad;          // some character broke the format
  logic [7:0] guid_acc [16];     // bytes assembled so far
  logic [3:0] hi_nibble;         // first digit of the pair in flight
  utp_res_t   guid_queue [$];    // expected results, oldest first

  logic [7:0] text_buf [MAX_TEXT];

  int  fail_count   = 0;
  int  chars_sent   = 0;
  int  texts_sent   = 0;
  int  results_seen = 0;
  int  good_uuids   = 0;
  int  idle_cycles  = 0;
  bit  send_idle    = 1'b1;
  bit  take_idle    = 1'b1;

  // 0..15 for a hex digit, 16 for anything else
  function automatic int nibble_of(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
    return 16;
  endfunction

  // Text position of the first digit of byte k; bytes 8 and 9 swap places
  function automatic int pair_start(int k);
    case (k)
      0: return 0;
      1: return 2;
      2: return 4;
      3: return 6;
      4: return 9;
      5: return 11;
      6: return 14;
      7: return 16;
      8: return 21;
      9: return 19;
      default: return 24 + 2 * (k - 10);
    endcase
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (nibble_of(c) < 16);
    return c;
  endfunction

  task automatic clear_parser();
    text_pos  = '0;
    text_bad  = 1'b0;
    hi_nibble = '0;
    for (int k = 0; k < UUID_BYTES; k++) guid_acc[k] = '0;
  endtask

  task automatic predict_char(logic [7:0] c, logic lst);
    int       at;
    int       v;
    int       slot;
    bit       second;
    utp_res_t r;
    at     = int'(text_pos);
    slot   = -1;
    second = 1'b0;
    for (int k = 0; k < UUID_BYTES; k++) begin
      if (pair_start(k) == at) slot = k;
      if (pair_start(k) + 1 == at) begin
        slot   = k;
        second = 1'b1;
      end
    end
    if (at >= UUID_LEN) begin
      text_bad = 1'b1;
    end else if (slot < 0) begin
      if (c != CH_DASH) text_bad = 1'b1;
    end else begin
      v = nibble_of(c);
      if (at == int'(POS_VERSION) && !(c >= CH_1 && c <= CH_5)) text_bad = 1'b1;
      if (at == int'(POS_VARIANT) && c != CH_8 && c != CH_9 && c != CH_UA && c != CH_UB)
        text_bad = 1'b1;
      if (second) begin
        // a pair cut short keeps the one digit as the byte value
        guid_acc[slot] = (v < 16) ? {hi_nibble, v[3:0]} : {4'h0, hi_nibble};
      end else if (v < 16) begin
        hi_nibble = v[3:0];
      end else begin
        text_bad  = 1'b1;
        hi_nibble = 4'h0;
      end
    end
    if (text_pos < POS_SAT) text_pos = text_pos + 1'b1;
    if (lst) begin
      r.valid_res = !text_bad && at == int'(POS_LAST);
      r.guid_high = '0;
      r.guid_low  = '0;
      if (r.valid_res) begin
        for (int k = 0; k < 8; k++) begin
          r.guid_high = {r.guid_high[55:0], guid_acc[k]};
          r.guid_low  = {r.guid_low[55:0], guid_acc[k + 8]};
        end
      end
      guid_queue.push_back(r);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Character side
  // ---------------------------------------------------------------------------

  // Wait before a beat; idling comes and goes in stretches
  function automatic int draw_wait(bit on);
    if (!on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // One character beat; valid stays up between beats when no gap is drawn
  task automatic send_char(logic [7:0] c, logic lst);
    int gap;
    if ($urandom_range(0, 59) == 0) send_idle = !send_idle;
    gap = draw_wait(send_idle);
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.ch    <= c;
    text_if.last  <= lst;
    do @(posedge clk); while (!text_if.ready);
    predict_char(c, lst);
    chars_sent++;
  endtask

  task automatic send_text(int len);
    for (int i = 0; i < len; i++) send_char(text_buf[i], i == len - 1);
    texts_sent++;
  endtask

  // Well-formed UUID in text_buf[0..35], random digits in mixed case
  task automatic fill_uuid();
    int d;
    int base;
    for (int p = 0; p < UUID_LEN; p++) begin
      d = $urandom_range(0, 15);
      if (p == 8 || p == 13 || p == 18 || p == 23) begin
        text_buf[p] = CH_DASH;
      end else if (p == int'(POS_VERSION)) begin
        text_buf[p] = CH_1 + 8'($urandom_range(0, 4));
      end else if (p == int'(POS_VARIANT)) begin
        case ($urandom_range(0, 3))
          0: text_buf[p] = CH_8;
          1: text_buf[p] = CH_9;
          2: text_buf[p] = CH_UA;
          default: text_buf[p] = CH_UB;
        endcase
      end else begin
        base = ($urandom_range(0, 1) != 0) ? int'(CH_LA) : int'(CH_UA);
        text_buf[p] = (d < 10) ? 8'(int'(CH_0) + d) : 8'(base + d - 10);
      end
    end
    // now and then a pair ends on a non-digit: still valid, one-digit byte
    if ($urandom_range(0, 3) == 0)
      text_buf[pair_start($urandom_range(0, 15)) + 1] = non_hex_char();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes: all-ones bytes, both letter cases, top version, variant 9,
  // a pair cut short, and one- and two-character texts
  task automatic test_directed_texts();
    string s;
    s = "ffffffff-FFFF-5fff-Bf9g-0123456789aA";
    for (int i = 0; i < s.len(); i++) text_buf[i] = s[i];
    send_text(s.len());
    text_buf[0] = 8'h00;
    send_text(1);
    text_buf[0] = 8'hFF;
    send_text(1);
    text_buf[0] = CH_DASH;
    text_buf[1] = CH_LA;
    send_text(2);
  endtask

  task automatic test_well_formed_uuids(int n);
    for (int i = 0; i < n; i++) begin
      fill_uuid();
      send_text(UUID_LEN);
    end
  endtask

  // Each way of breaking a text comes up once in turn, then at random
  task automatic test_broken_uuids(int n);
    int          len;
    logic [7:0]  c;
    break_kind_e kind;
    for (int i = 0; i < n; i++) begin
      fill_uuid();
      len  = UUID_LEN;
      kind = (i < BREAK_COUNT) ? break_kind_e'(i)
                               : break_kind_e'($urandom_range(0, BREAK_COUNT - 1));
      case (kind)
        BREAK_DASH: begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_DASH);
          case ($urandom_range(0, 3))
            0: text_buf[8]  = c;
            1: text_buf[13] = c;
            2: text_buf[18] = c;
            default: text_buf[23] = c;
          endcase
        end
        BREAK_VERSION: begin
          do c = 8'($urandom_range(0, 1) ? $urandom_range(CH_0, CH_LF)
                                         : $urandom_range(0, 255));
          while (c >= CH_1 && c <= CH_5);
          text_buf[POS_VERSION] = c;
        end
        BREAK_VARIANT: begin
          // lower-case a and b land here too
          do c = 8'($urandom_range(0, 1) ? $urandom_range(CH_0, CH_LF)
                                         : $urandom_range(0, 255));
          while (c == CH_8 || c == CH_9 || c == CH_UA || c == CH_UB);
          text_buf[POS_VARIANT] = c;
        end
        BREAK_FIRST_DIGIT: text_buf[pair_start($urandom_range(0, 15))] = non_hex_char();
        BREAK_SHORT:       len = $urandom_range(1, UUID_LEN - 1);
        BREAK_LONG: begin
          len = $urandom_range(UUID_LEN + 1, UUID_LEN + 12);
          for (int p = UUID_LEN; p < len; p++) text_buf[p] = 8'($urandom_range(0, 255));
        end
        default: ;
      endcase
      send_text(len);
    end
  endtask

  // Raw streams, half the characters from the dash-to-'f' band
  task automatic test_random_streams(int n);
    int len;
    for (int i = 0; i < n; i++) begin
      len = $urandom_range(1, UUID_LEN + 9);
      for (int p = 0; p < len; p++)
        text_buf[p] = 8'($urandom_range(0, 1) ? $urandom_range(CH_DASH, CH_LF)
                                              : $urandom_range(0, 255));
      send_text(len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, sometimes with a beat already waiting
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 59) == 0) take_idle = !take_idle;
      stall = draw_wait(take_idle);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        if ($urandom_range(0, 1)) begin
          do @(posedge clk); while (!result_if.valid);
        end
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  // Each result beat against the oldest expectation
  always @(posedge clk) begin : check_beat
    utp_res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      results_seen++;
      if (guid_queue.size() == 0) begin
        $display("%0t: result beat with nothing expected: valid_res %0b high %h low %h",
                 $time, result_if.valid_res, result_if.guid_high, result_if.guid_low);
        fail_count++;
      end else begin
        want = guid_queue.pop_front();
        if (want.valid_res) good_uuids++;
        if (result_if.valid_res !== want.valid_res) begin
          $display("%0t: valid_res expected %0b, got %0b",
                   $time, want.valid_res, result_if.valid_res);
          fail_count++;
        end
        if (result_if.guid_high !== want.guid_high) begin
          $display("%0t: guid_high expected %h, got %h",
                   $time, want.guid_high, result_if.guid_high);
          fail_count++;
        end
        if (result_if.guid_low !== want.guid_low) begin
          $display("%0t: guid_low expected %h, got %h",
                   $time, want.guid_low, result_if.guid_low);
          fail_count++;
        end
      end
    end
  end

  // Hang detector: counts cycles without a beat on either channel
  always @(posedge clk) begin
    if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still expected",
               $time, idle_cycles, guid_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    text_if.valid <= 1'b0;
    text_if.ch    <= '0;
    text_if.last  <= 1'b0;
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_texts();
    test_well_formed_uuids(18);
    test_broken_uuids(12);
    test_random_streams(8);
    text_if.valid <= 1'b0;

    // drain, then a short quiet spell to catch anything extra
    while (guid_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d texts, well-formed, broken and raw",
             chars_sent, texts_sent);
    $display("Checked %0d results, %0d of them parsed UUIDs", results_seen, good_uuids);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/utp_pkg.sv
hdl/utp_stream_if.sv
hdl/utp_char_decode.sv
hdl/utp_accum.sv
hdl/uuid_text_parser.sv
dv/uuid_text_parser_test.sv
